>>> sv/tbcd_pkg.sv
// Package for the two-button click-code decoder.
// Holds the shared constants, register indexes, item kinds and the structs
// that pass between the front end, the queues and the back end. No dependencies.
package tbcd_pkg;

   // Widths fixed by the interface.
   localparam int NOW_BITS          = 32;
   localparam int CFG_BITS          = 16;
   localparam int CODE_BITS         = 6;
   localparam int CLICK_BITS        = 3;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   // Defaults for the top-level parameters.
   localparam int TIME_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET    = 16'd10;
   localparam logic [CFG_BITS-1:0] PRESS_SPLIT_RESET = 16'd165;
   localparam logic [CFG_BITS-1:0] TIMEOUT_RESET     = 16'd500;

   // Click values: the base names the buttons, plus one for a long press.
   localparam logic [CLICK_BITS-1:0] BASE_BUTTON0 = 3'd0;
   localparam logic [CLICK_BITS-1:0] BASE_BUTTON1 = 3'd2;
   localparam logic [CLICK_BITS-1:0] BASE_BOTH    = 3'd4;
   localparam logic [CODE_BITS-1:0]  CODE_RADIX   = 6'd6;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_PRESS_SPLIT = 2'd1,
      CSR_TIMEOUT     = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_EDGE = 1'b0,
      KIND_POLL = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          button;
   } item_head_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] press_split_ms;
      logic [CFG_BITS-1:0] gesture_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic                 code_valid;
      logic [CODE_BITS-1:0] gesture_code;
   } rsp_type;

endpackage

>>> sv/tbcd_fifo.sv
// Small first-in first-out queue built from registers.
// Used between the front and back ends and on the result side; no package needed.
// DEPTH must be a power of two of at least two.
module tbcd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == COUNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointers wrap by overflow since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/tbcd_front.sv
// Front end of the click-code decoder: takes requests and classifies them.
// Depends on tbcd_pkg for the item kinds and the item header struct.
module tbcd_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_mode,
   input  logic                    req_button,
   input  logic [31:0]             req_now_ms,
   output logic                    item_valid,
   output tbcd_pkg::item_head_type item_head,
   output logic [TIME_BITS-1:0]    item_now,
   input  logic                    item_ready
);
   import tbcd_pkg::*;

   logic                 valid_ff, valid_in;
   item_head_type        head_ff, head_in;
   logic [TIME_BITS-1:0] now_ff;
   logic                 take;

   assign req_full   = valid_ff & ~item_ready;
   assign take       = req_push & ~req_full;
   assign item_valid = valid_ff;
   assign item_head  = head_ff;
   assign item_now   = now_ff;

   always_comb begin
      valid_in = take | (valid_ff & ~item_ready);
      head_in.button = req_button;
      unique case (req_mode)
         1'b0:    head_in.kind = KIND_EDGE;
         1'b1:    head_in.kind = KIND_POLL;
         default: head_in.kind = KIND_EDGE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Timestamps are kept modulo 2^TIME_BITS from here on.
   always_ff @(posedge clock) begin
      if (take) begin
         head_ff <= head_in;
         now_ff  <= TIME_BITS'(req_now_ms);
      end
   end

endmodule

>>> sv/tbcd_back.sv
// Back end of the click-code decoder: debounce, click classification and
// gesture accumulation. Depends on tbcd_pkg for the structs and constants.
module tbcd_back #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tbcd_pkg::cfg_type       cfg,
   input  logic                    go,
   input  tbcd_pkg::item_head_type head,
   input  logic [TIME_BITS-1:0]    now,
   output tbcd_pkg::rsp_type       rsp
);
   import tbcd_pkg::*;

   logic [1:0]           held_ff, held_in;
   logic [1:0]           psc_ff, psc_in;
   logic [TIME_BITS-1:0] last_ff [2];
   logic [TIME_BITS-1:0] last_in [2];
   logic [CODE_BITS-1:0] accum_ff, accum_in;
   logic                 count_ff, count_in;

   logic [TIME_BITS-1:0]  age0, age1, shorter, age_sel;
   logic [CLICK_BITS-1:0] base, value;
   logic                  is_long;

   // Ages wrap modulo 2^TIME_BITS through the natural width of the subtract.
   always_comb begin
      age0    = now - last_ff[0];
      age1    = now - last_ff[1];
      shorter = (age0 < age1) ? age0 : age1;
      age_sel = head.button ? age1 : age0;
      is_long = ~(shorter < TIME_BITS'(cfg.press_split_ms));
      if (psc_ff[0] & psc_ff[1]) begin
         base = BASE_BOTH;
      end else if (psc_ff[1]) begin
         base = BASE_BUTTON1;
      end else begin
         base = BASE_BUTTON0;
      end
      value = base + CLICK_BITS'(is_long);
   end

   always_comb begin
      held_in  = held_ff;
      psc_in   = psc_ff;
      last_in  = last_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      rsp      = '0;
      if (go) begin
         unique case (head.kind)
            KIND_EDGE: begin
               if (age_sel > TIME_BITS'(cfg.debounce_ms)) begin
                  held_in[head.button] = ~held_ff[head.button];
                  last_in[head.button] = now;
                  if (!held_ff[head.button]) begin
                     psc_in[head.button] = 1'b1;
                  end else if (psc_ff != 2'b00) begin
                     // A release that completes a click.
                     psc_in = 2'b00;
                     if (count_ff) begin
                        rsp.code_valid   = 1'b1;
                        rsp.gesture_code = accum_ff + CODE_BITS'(value);
                        accum_in         = '0;
                        count_in         = 1'b0;
                     end else begin
                        accum_in = CODE_BITS'(value) * CODE_RADIX;
                        count_in = 1'b1;
                     end
                  end
               end
            end
            KIND_POLL: begin
               if ((shorter >= TIME_BITS'(cfg.gesture_timeout_ms)) && count_ff) begin
                  held_in  = 2'b00;
                  psc_in   = 2'b00;
                  accum_in = '0;
                  count_in = 1'b0;
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         psc_ff     <= '0;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         accum_ff   <= '0;
         count_ff   <= 1'b0;
      end else begin
         held_ff    <= held_in;
         psc_ff     <= psc_in;
         last_ff[0] <= last_in[0];
         last_ff[1] <= last_in[1];
         accum_ff   <= accum_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> sv/two_button_click_code_decoder_core.sv
// Top level of the two-button click-code decoder.
// Depends on tbcd_pkg, tbcd_fifo, tbcd_front and tbcd_back.
//
// Usage: every request is either a button edge (mode 0, with the button
// number and a millisecond timestamp) or a timeout poll (mode 1). A request
// is taken on a clock edge where req_push is high and req_full is low.
// Every request yields exactly one response, in request order. A response
// carries rsp_code_valid, which is high when a two-click gesture completed,
// and rsp_gesture_code (first click times six plus second click, else zero).
// A response is shown while rsp_empty is low and is consumed on rsp_pop.
// A request is held in the front register, then in the request queue, then
// passes through the back end into the response queue, clearing rsp_empty.
// Throughput is one request per cycle while the receiver keeps up; the back end
// updates its state once per request. When the receiver stalls, responses pile
// up in the response queue, then the request queue and the front register fill
// and req_full rises; nothing is dropped. Synchronous reset empties both queues,
// clears all button and gesture state and loads the registers with their
// defaults (debounce 10, split 165, timeout 500). Registers are written through
// the csr_ port at byte addresses 0, 4 and 8. The user must write them only while
// no request is in flight; the block itself does not enforce it.
module two_button_click_code_decoder_core #(
   parameter int TIME_BITS   = tbcd_pkg::TIME_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = tbcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_mode,
   input  logic                               req_button,
   input  logic [tbcd_pkg::NOW_BITS-1:0]      req_now_ms,
   // Response channel.
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_code_valid,
   output logic [tbcd_pkg::CODE_BITS-1:0]     rsp_gesture_code,
   // Register port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tbcd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tbcd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tbcd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import tbcd_pkg::*;

   localparam int ITEM_BITS = $bits(item_head_type) + TIME_BITS;
   localparam int RSP_BITS  = $bits(rsp_type);

   // Register file. Each register is 16 bits; the upper write data is dropped.
   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    cfg_in.debounce_ms        = csr_pwdata[CFG_BITS-1:0];
            CSR_PRESS_SPLIT: cfg_in.press_split_ms     = csr_pwdata[CFG_BITS-1:0];
            CSR_TIMEOUT:     cfg_in.gesture_timeout_ms = csr_pwdata[CFG_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_DEBOUNCE:    csr_prdata = CSR_DATA_BITS'(cfg_ff.debounce_ms);
         CSR_PRESS_SPLIT: csr_prdata = CSR_DATA_BITS'(cfg_ff.press_split_ms);
         CSR_TIMEOUT:     csr_prdata = CSR_DATA_BITS'(cfg_ff.gesture_timeout_ms);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_RESET;
         cfg_ff.press_split_ms     <= PRESS_SPLIT_RESET;
         cfg_ff.gesture_timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts requests and tags each one as an edge or a poll.
   logic                 front_valid;
   item_head_type        front_head;
   logic [TIME_BITS-1:0] front_now;
   logic                 item_full;

   tbcd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_button (req_button),
      .req_now_ms (req_now_ms),
      .item_valid (front_valid),
      .item_head  (front_head),
      .item_now   (front_now),
      .item_ready (~item_full)
   );

   // Request queue between the front and back ends.
   logic [ITEM_BITS-1:0] item_rd;
   logic                 item_empty;
   logic                 rsp_full;
   logic                 back_go;
   item_head_type        back_head;
   logic [TIME_BITS-1:0] back_now;

   tbcd_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .wr_data ({front_head, front_now}),
      .full    (item_full),
      .pop     (back_go),
      .rd_data (item_rd),
      .empty   (item_empty)
   );

   // The back end runs one request per cycle whenever the response queue has room.
   assign back_go                = ~item_empty & ~rsp_full;
   assign {back_head, back_now}  = item_rd;

   rsp_type back_rsp;

   tbcd_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .go    (back_go),
      .head  (back_head),
      .now   (back_now),
      .rsp   (back_rsp)
   );

   // Response queue decouples the back end from a stalling receiver.
   rsp_type out_rsp;

   tbcd_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_go),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (out_rsp),
      .empty   (rsp_empty)
   );

   assign rsp_code_valid   = out_rsp.code_valid;
   assign rsp_gesture_code = out_rsp.gesture_code;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the two-button click-code decoder (two_button_click_code_decoder_core).
// It keeps its own model of the gesture state and compares every response with it.
// Depends only on tbcd_pkg and the decoder RTL.
module testbench;
   import tbcd_pkg::*;

   // Register index that decodes to no register; writes to it must be ignored.
   localparam logic [1:0] UNUSED_INDEX = 2'd3;
   // Cycles left for the pipeline after the last response, with some slack.
   localparam int SETTLE_CYCLES = 6;
   // Anything near this limit means a hang.
   localparam int CYCLE_LIMIT = 200000;

   // Clock, reset and every block input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_mode = 1'b0;
   logic req_button = 1'b0;
   logic [NOW_BITS-1:0] req_now_ms = '0;
   logic rsp_pop = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;

   logic req_full;
   logic rsp_empty;
   logic rsp_code_valid;
   logic [CODE_BITS-1:0] rsp_gesture_code;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // Gesture state as the decoder should hold it, plus the register settings.
   logic btn_held [2] = '{1'b0, 1'b0};
   logic btn_pressed [2] = '{1'b0, 1'b0};
   logic [NOW_BITS-1:0] btn_last_edge [2] = '{'0, '0};
   logic [CODE_BITS-1:0] code_sum = '0;
   logic first_click_done = 1'b0;
   logic [CFG_BITS-1:0] cfg_debounce = DEBOUNCE_RESET;
   logic [CFG_BITS-1:0] cfg_split = PRESS_SPLIT_RESET;
   logic [CFG_BITS-1:0] cfg_timeout = TIMEOUT_RESET;

   // Responses predicted for accepted requests, oldest first.
   rsp_type expected_responses [$];

   // Timeline that the stimulus advances; it wraps like the real timestamp.
   logic [NOW_BITS-1:0] stim_ms = '0;

   // Knobs for the two sides of the handshake.
   bit sender_gaps_on = 1'b1;
   bit receiver_gaps_on = 1'b1;
   int receiver_hold_cycles = 0;

   int requests_sent = 0;
   int responses_checked = 0;
   int gestures_expected = 0;
   int register_writes = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   two_button_click_code_decoder_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_button       (req_button),
      .req_now_ms       (req_now_ms),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_code_valid   (rsp_code_valid),
      .rsp_gesture_code (rsp_gesture_code),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_responses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Advances the gesture state by one request and returns the response it causes.
   // Ages are 32-bit differences, so the timestamp wrap comes for free.
   function automatic rsp_type predict_response(input item_kind_type kind, input logic button,
                                                input logic [NOW_BITS-1:0] now_ms);
      rsp_type result;
      logic [NOW_BITS-1:0] age0, age1, shorter, own_age;
      logic [CLICK_BITS-1:0] click;
      result = '0;
      age0 = now_ms - btn_last_edge[0];
      age1 = now_ms - btn_last_edge[1];
      shorter = (age0 < age1) ? age0 : age1;
      if (kind == KIND_EDGE) begin
         own_age = button ? age1 : age0;
         if (own_age > cfg_debounce) begin
            btn_held[button] = !btn_held[button];
            if (btn_held[button]) begin
               btn_pressed[button] = 1'b1;
            end else if (btn_pressed[0] || btn_pressed[1]) begin
               // A release closes a click; the buttons seen since the last click
               // pick the base, the shorter hold decides short or long.
               if (btn_pressed[0] && btn_pressed[1]) begin
                  click = BASE_BOTH;
               end else if (btn_pressed[1]) begin
                  click = BASE_BUTTON1;
               end else begin
                  click = BASE_BUTTON0;
               end
               if (shorter >= cfg_split) begin
                  click = click + 1'b1;
               end
               code_sum = code_sum + CODE_BITS'(click);
               btn_pressed[0] = 1'b0;
               btn_pressed[1] = 1'b0;
               if (first_click_done) begin
                  result.code_valid = 1'b1;
                  result.gesture_code = code_sum;
                  code_sum = '0;
                  first_click_done = 1'b0;
               end else begin
                  first_click_done = 1'b1;
                  code_sum = code_sum * CODE_RADIX;
               end
            end
            btn_last_edge[button] = now_ms;
         end
      end else if (shorter >= cfg_timeout && first_click_done) begin
         // A stale half gesture is dropped, held flags included.
         btn_held[0] = 1'b0;
         btn_held[1] = 1'b0;
         btn_pressed[0] = 1'b0;
         btn_pressed[1] = 1'b0;
         code_sum = '0;
         first_click_done = 1'b0;
      end
      return result;
   endfunction

   // Every accepted request gets its prediction at the edge that takes it.
   always @(posedge clock) begin : request_monitor
      rsp_type want;
      if (!reset && req_push && !req_full) begin
         want = predict_response(item_kind_type'(req_mode), req_button, req_now_ms);
         expected_responses.push_back(want);
         if (want.code_valid) begin
            gestures_expected++;
         end
      end
   end

   task automatic report_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, detail);
      end
   endtask

   // Each popped response is compared field by field with the oldest prediction.
   always @(posedge clock) begin : response_checker
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         responses_checked++;
         if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("response with no request pending (valid %b, code %0d)",
                                      rsp_code_valid, rsp_gesture_code));
         end else begin
            want = expected_responses.pop_front();
            if (rsp_code_valid !== want.code_valid) begin
               report_mismatch($sformatf("response %0d code_valid expected %b, got %b",
                                         responses_checked, want.code_valid, rsp_code_valid));
            end
            if (rsp_gesture_code !== want.gesture_code) begin
               report_mismatch($sformatf("response %0d gesture_code expected %0d, got %0d",
                                         responses_checked, want.gesture_code, rsp_gesture_code));
            end
         end
      end
   end

   // Receiver side. It pops whenever it can, except for random stall bursts and
   // for a long hold-off that a test can request. The hold-off is counted here
   // so that the sender keeps running meanwhile.
   initial begin : response_receiver
      int stall;
      forever begin
         @(posedge clock);
         if (receiver_hold_cycles > 0) begin
            stall = receiver_hold_cycles;
            receiver_hold_cycles = 0;
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end else if (receiver_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offers one request and returns at the edge that accepts it. A random gap
   // may come first, so that idle cycles land on every phase.
   task automatic send_request(input item_kind_type kind, input logic button,
                               input logic [NOW_BITS-1:0] now_ms);
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_mode <= kind;
      req_button <= button;
      req_now_ms <= now_ms;
      @(posedge clock);
      while (req_full) @(posedge clock);
      requests_sent++;
   endtask

   // Stops offering and waits until every predicted response has been checked.
   task automatic wait_all_responses();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup, then access; the register takes the
   // value at the access edge since pready is always high. The address is
   // still on the port afterwards, so the new value is read back.
   task automatic write_register(input logic [1:0] index, input logic [CFG_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {{(CSR_DATA_BITS - CFG_BITS){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         CSR_DEBOUNCE:    cfg_debounce = value;
         CSR_PRESS_SPLIT: cfg_split = value;
         CSR_TIMEOUT:     cfg_timeout = value;
         default:         ;
      endcase
      register_writes++;
      @(posedge clock);
      if (csr_pready !== 1'b1) begin
         report_mismatch($sformatf("csr_pready expected 1, got %b", csr_pready));
      end
      if (index != UNUSED_INDEX && csr_prdata !== CSR_DATA_BITS'(value)) begin
         report_mismatch($sformatf("register %0d read back expected %0d, got %0d",
                                   index, value, csr_prdata));
      end
   endtask

   task automatic write_settings(input logic [CFG_BITS-1:0] debounce,
                                 input logic [CFG_BITS-1:0] split,
                                 input logic [CFG_BITS-1:0] timeout);
      write_register(CSR_DEBOUNCE, debounce);
      write_register(CSR_PRESS_SPLIT, split);
      write_register(CSR_TIMEOUT, timeout);
   endtask

   // Spacing between edges: mostly just past the debounce window, sometimes
   // exactly on it so that the edge is dropped.
   function automatic logic [NOW_BITS-1:0] edge_spacing();
      if ($urandom_range(0, 7) == 0) begin
         return NOW_BITS'(cfg_debounce);
      end
      return cfg_debounce + $urandom_range(1, 40);
   endfunction

   // Hold time clustered around the short/long split, kept beyond the
   // debounce window most of the time so that the release counts.
   function automatic logic [NOW_BITS-1:0] hold_length();
      logic [NOW_BITS-1:0] hold;
      case ($urandom_range(0, 3))
         0:       hold = (cfg_split == 0) ? '0 : cfg_split - 1;
         1:       hold = cfg_split;
         2:       hold = cfg_split + 1;
         default: hold = $urandom_range(0, 2 * cfg_split + 50);
      endcase
      if (hold <= cfg_debounce && $urandom_range(0, 3) != 0) begin
         hold = cfg_debounce + 1 + $urandom_range(0, 20);
      end
      return hold;
   endfunction

   // Quiet time before a poll, clustered around the gesture timeout.
   function automatic logic [NOW_BITS-1:0] quiet_length();
      case ($urandom_range(0, 3))
         0:       return (cfg_timeout == 0) ? '0 : cfg_timeout - 1;
         1:       return cfg_timeout;
         2:       return cfg_timeout + 1;
         default: return $urandom_range(0, 2 * cfg_timeout + 100);
      endcase
   endfunction

   // One well-formed click: a single button pressed and released, or both
   // buttons pressed together and released one after the other.
   task automatic send_click();
      logic lead_button;
      logic both;
      lead_button = 1'($urandom_range(0, 1));
      both = ($urandom_range(0, 2) == 0);
      stim_ms += edge_spacing();
      send_request(KIND_EDGE, lead_button, stim_ms);
      if (both) begin
         stim_ms += $urandom_range(0, 60);
         send_request(KIND_EDGE, !lead_button, stim_ms);
      end
      stim_ms += hold_length();
      send_request(KIND_EDGE, lead_button, stim_ms);
      if (both) begin
         stim_ms += $urandom_range(0, 60);
         send_request(KIND_EDGE, !lead_button, stim_ms);
      end
   endtask

   // Mostly clicks, which pair up into gestures; the rest is polls, contact
   // bounce inside the debounce window, fully random requests and jumps of the
   // timeline, often to just before the 32-bit wrap.
   task automatic random_action();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: send_click();
         6: begin
            stim_ms += quiet_length();
            send_request(KIND_POLL, 1'($urandom_range(0, 1)), stim_ms);
         end
         7: send_request(item_kind_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom());
         8: begin
            stim_ms += $urandom_range(0, cfg_debounce);
            send_request(KIND_EDGE, 1'($urandom_range(0, 1)), stim_ms);
         end
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               stim_ms = $urandom();
            end else begin
               stim_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
            end
            send_click();
         end
      endcase
   endtask

   task automatic run_random_requests(input int count);
      int first_sent;
      first_sent = requests_sent;
      while (requests_sent - first_sent < count) random_action();
   endtask

   // Hand-picked sequence under the reset settings (debounce 10, split 165,
   // timeout 500). Each step names the behavior it targets.
   task automatic test_directed_cases();
      // Edges right after reset: the stored edge times are zero, so edges at
      // 5 and at exactly 10 fall inside the debounce window and are dropped.
      send_request(KIND_EDGE, 1'b0, 32'd5);
      send_request(KIND_EDGE, 1'b1, 32'd10);
      // Poll at time zero with nothing pending changes nothing.
      send_request(KIND_POLL, 1'b1, 32'd0);
      // Short click on button 0, then long click on button 1: code 3.
      send_request(KIND_EDGE, 1'b0, 32'd100);
      send_request(KIND_EDGE, 1'b0, 32'd150);
      send_request(KIND_EDGE, 1'b1, 32'd300);
      send_request(KIND_EDGE, 1'b1, 32'd600);
      // Both buttons, long. The release of button 1 afterwards has no press
      // recorded since the click, so it is taken but counts as no click.
      send_request(KIND_EDGE, 1'b0, 32'd1000);
      send_request(KIND_EDGE, 1'b1, 32'd1020);
      send_request(KIND_EDGE, 1'b0, 32'd1300);
      send_request(KIND_EDGE, 1'b1, 32'd1310);
      // Short click on button 0 completes the gesture: code 30.
      send_request(KIND_EDGE, 1'b0, 32'd2000);
      send_request(KIND_EDGE, 1'b0, 32'd2100);
      // Half gesture, a poll just before the timeout (kept) and one exactly
      // at it (cleared); the poll carries button 1, which must not matter.
      send_request(KIND_EDGE, 1'b0, 32'd3000);
      send_request(KIND_EDGE, 1'b0, 32'd3050);
      send_request(KIND_POLL, 1'b0, 32'd3400);
      send_request(KIND_POLL, 1'b1, 32'd3550);
      send_request(KIND_EDGE, 1'b1, 32'd3600);
      send_request(KIND_EDGE, 1'b1, 32'd3700);
      // Button 0 is held when a timeout clears the half gesture; its next
      // edge must then count as a press, not a release.
      send_request(KIND_EDGE, 1'b0, 32'd4000);
      send_request(KIND_POLL, 1'b0, 32'd4600);
      send_request(KIND_EDGE, 1'b0, 32'd4700);
      // Release at the top of the time range, then a click across the wrap.
      send_request(KIND_EDGE, 1'b0, 32'hFFFF_FFFF);
      send_request(KIND_EDGE, 1'b1, 32'h0000_000F);
      send_request(KIND_EDGE, 1'b1, 32'h0000_002F);
      stim_ms = 32'h0000_0100;
   endtask

   // All registers at zero and then at their maximum; the unused register
   // index is written after the maximum and must leave the settings alone.
   task automatic test_threshold_extremes();
      wait_all_responses();
      write_settings(16'h0000, 16'h0000, 16'h0000);
      run_random_requests(50);
      wait_all_responses();
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_register(UNUSED_INDEX, 16'h0001);
      run_random_requests(50);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         wait_all_responses();
         write_settings(CFG_BITS'($urandom_range(0, 100)), CFG_BITS'($urandom_range(1, 600)),
                        CFG_BITS'($urandom_range(0, 2000)));
         run_random_requests(100);
      end
   endtask

   // The receiver stops for a long stretch while the sender keeps pushing
   // back to back, so the queues fill up and req_full must stall the input.
   task automatic test_output_backpressure();
      wait_all_responses();
      write_settings(DEBOUNCE_RESET, PRESS_SPLIT_RESET, TIMEOUT_RESET);
      sender_gaps_on = 1'b0;
      receiver_hold_cycles = 300;
      run_random_requests(40);
      sender_gaps_on = 1'b1;
   endtask

   // The sender goes quiet until everything has come out, then resumes.
   task automatic test_sender_pause();
      run_random_requests(30);
      wait_all_responses();
      run_random_requests(30);
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_streaming_without_gaps();
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      run_random_requests(80);
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_threshold_extremes();
      test_random_settings();
      test_output_backpressure();
      test_sender_pause();
      test_streaming_without_gaps();

      wait_all_responses();
      $display("Covered %0d requests and %0d responses, %0d of them completed gestures,",
               requests_sent, responses_checked, gestures_expected);
      $display("over %0d register writes incl. zero and full-scale settings and a long stall.",
               register_writes);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> two_button_click_code_decoder_core.f
sv/tbcd_pkg.sv
sv/tbcd_fifo.sv
sv/tbcd_front.sv
sv/tbcd_back.sv
sv/two_button_click_code_decoder_core.sv
bench/testbench.sv
